@@ src/assert_macros.svh @@
// assertion macros for the ready queue
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPL(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error("lbl");
`define ASSERT_NEXT(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error("lbl");
`else
`define ASSERT_IMPL(lbl, clk, rst_n, a, c)
`define ASSERT_NEXT(lbl, clk, rst_n, a, c)
`endif
`endif

@@ src/prq_pkg.sv @@
// package for the priority ready queue: sizes, command codes, control types
// no dependencies
package prq_pkg;
	localparam int THREADS_DEF = 64;
	localparam int LEVELS_DEF = 32;
	localparam int CMD_W = 3;
	localparam int TID_W = 6;
	localparam int PRI_W = 5;
	localparam int RND_W = 32;
	localparam int STAT_W = 2;
	localparam int CNT_W = 7;

	localparam logic [CMD_W-1:0] CMD_PUSH_TAIL = 3'd0;
	localparam logic [CMD_W-1:0] CMD_PUSH_HEAD = 3'd1;
	localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd2;
	localparam logic [CMD_W-1:0] CMD_POP = 3'd3;
	localparam logic [CMD_W-1:0] CMD_PEEK = 3'd4;
	localparam logic [CMD_W-1:0] CMD_POP_RAND = 3'd5;

	localparam logic [STAT_W-1:0] ST_OK = 2'd0;
	localparam logic [STAT_W-1:0] ST_MISS = 2'd1;
	localparam logic [STAT_W-1:0] ST_DUP = 2'd2;

	typedef enum logic [3:0] {
		S_IDLE, S_DECODE, S_SCAN, S_MOD, S_WALK_HEAD, S_WALK, S_UNLINK, S_DONE
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;      // capture request
		logic push;      // perform push
		logic scan_init; // start level scan from the top
		logic scan_step; // move scan one level down
		logic mod_init;
		logic mod_step;
		logic walk_head; // start walk at head of current level
		logic walk_step; // advance walk to next link
		logic unlink;    // remove current walk thread
		logic set_res;   // finalize result
		logic res_found;
		logic [STAT_W-1:0] res_status;
	} prq_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic tid_ok;
		logic queued;
		logic lvl_ne;     // current level nonempty
		logic scan_last;  // current level is zero
		logic mod_done;
		logic any_ready;
		logic hit;        // walk reached target
		logic more;       // walk has a successor
	} prq_sts_t;
endpackage

@@ src/prq_ctrl.sv @@
// controller state machine for the priority ready queue
// depends on prq_pkg
module prq_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	output logic out_valid,
	input  logic out_stall,
	input  prq_pkg::prq_sts_t sts,
	output prq_pkg::prq_cmd_t cmd
);
	import prq_pkg::*;

	state_t state_q, state_d;
	logic out_valid_q, out_valid_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			out_valid_q <= out_valid_d;
		end
	end

	assign out_valid = out_valid_q;
	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd = '0;
		out_valid_d = out_valid_q && out_stall;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				case (sts.cmd)
					CMD_PUSH_TAIL, CMD_PUSH_HEAD: begin
						if (!sts.tid_ok) cmd.res_status = ST_MISS;
						else if (sts.queued) cmd.res_status = ST_DUP;
						else begin
							cmd.push = 1'b1;
							cmd.res_status = ST_OK;
						end
						state_d = S_DONE;
					end
					CMD_REMOVE: begin
						if (sts.tid_ok && sts.queued) begin
							cmd.walk_head = 1'b1;
							state_d = S_WALK_HEAD;
						end else begin
							cmd.res_status = ST_MISS;
							state_d = S_DONE;
						end
					end
					CMD_POP, CMD_PEEK: begin
						cmd.scan_init = 1'b1;
						state_d = S_SCAN;
					end
					CMD_POP_RAND: begin
						if (sts.any_ready) begin
							cmd.mod_init = 1'b1;
							state_d = S_MOD;
						end else begin
							cmd.res_status = ST_MISS;
							state_d = S_DONE;
						end
					end
					default: begin
						cmd.res_status = ST_OK;
						state_d = S_DONE;
					end
				endcase
			end
			S_MOD: begin
				if (sts.mod_done) begin
					cmd.scan_init = 1'b1;
					state_d = S_SCAN;
				end else cmd.mod_step = 1'b1;
			end
			S_SCAN: begin
				if (sts.lvl_ne) begin
					if (sts.cmd == CMD_PEEK) begin
						cmd.res_found = 1'b1;
						cmd.res_status = ST_OK;
						state_d = S_DONE;
					end else begin
						cmd.walk_head = 1'b1;
						state_d = S_WALK_HEAD;
					end
				end else if (sts.scan_last) begin
					cmd.res_status = ST_MISS;
					state_d = S_DONE;
				end else cmd.scan_step = 1'b1;
			end
			S_WALK_HEAD, S_WALK: begin
				// head/link reads are registered, so each step passes through a settle state (S_WALK_HEAD)
				if (state_q == S_WALK_HEAD) state_d = S_WALK;
				else if (sts.hit) state_d = S_UNLINK;
				else if (sts.more) begin
					cmd.walk_step = 1'b1;
					state_d = S_WALK_HEAD;
				end else if (sts.cmd == CMD_POP_RAND) begin
					// level exhausted: continue scanning lower levels
					if (sts.scan_last) begin
						cmd.res_status = ST_MISS;
						state_d = S_DONE;
					end else begin
						cmd.scan_step = 1'b1;
						state_d = S_SCAN;
					end
				end else begin
					cmd.res_status = ST_MISS;
					state_d = S_DONE;
				end
			end
			S_UNLINK: begin
				cmd.unlink = 1'b1;
				cmd.res_found = (sts.cmd != CMD_REMOVE);
				cmd.res_status = ST_OK;
				state_d = S_DONE;
			end
			S_DONE: begin
				if (!out_valid_q || !out_stall) begin
					cmd.set_res = 1'b1;
					out_valid_d = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// result status/found must be held until S_DONE: latched when nonzero or on push/unlink
endmodule

@@ src/prq_dpath.sv @@
// datapath for the priority ready queue: link tables, level scan, modulo, walk
// depends on prq_pkg
module prq_dpath #(
	parameter int THREADS = prq_pkg::THREADS_DEF,
	parameter int LEVELS = prq_pkg::LEVELS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  prq_pkg::prq_cmd_t cmd,
	output prq_pkg::prq_sts_t sts,
	input  logic [prq_pkg::CMD_W-1:0] command,
	input  logic [prq_pkg::TID_W-1:0] thread_id,
	input  logic [prq_pkg::PRI_W-1:0] priority_req,
	input  logic [prq_pkg::RND_W-1:0] random_value,
	output logic found,
	output logic [prq_pkg::TID_W-1:0] thread_out,
	output logic [prq_pkg::PRI_W-1:0] level_out,
	output logic [prq_pkg::STAT_W-1:0] status,
	output logic [prq_pkg::CNT_W-1:0] ready_total
);
	import prq_pkg::*;

	localparam int TW = $clog2(THREADS);
	localparam int LW = $clog2(LEVELS);
	localparam int RC_W = $clog2(THREADS + 1);

	// per-level and per-thread tables
	logic [TW-1:0] head_q [LEVELS];
	logic [TW-1:0] tail_q [LEVELS];
	logic [LEVELS-1:0] lne_q;
	logic [TW-1:0] link_q [THREADS];
	logic [THREADS-1:0] nvalid_q;
	logic [LW-1:0] tlvl_q [THREADS];
	logic [THREADS-1:0] queued_q;
	logic [RC_W-1:0] count_q;

	// request registers
	logic [CMD_W-1:0] cmd_q;
	logic [TW-1:0] tid_q;
	logic tid_ok_q;
	logic [LW-1:0] pri_q;
	logic [RND_W-1:0] rnd_q;

	// walk and scan
	logic [LW-1:0] lvl_q;
	logic [TW-1:0] it_q, prev_q;
	logic has_prev_q;
	logic [RC_W-1:0] k_q;

	// modulo by restoring division, one quotient bit per cycle
	logic [RC_W:0] rem_q;
	logic [5:0] mbit_q;
	logic mod_done_q;
	logic [RC_W:0] rem_sh;

	logic [STAT_W-1:0] st_q;
	logic fnd_q;
	logic found_q;
	logic [TID_W-1:0] tout_q;
	logic [PRI_W-1:0] lout_q;
	logic [STAT_W-1:0] status_q;
	logic [CNT_W-1:0] total_q;

	logic [TW-1:0] t_in;
	logic [LW-1:0] p_in;
	logic is_hit;

	function automatic logic state_set(prq_cmd_t c);
		state_set = c.res_status != ST_OK || c.res_found || c.unlink || c.push;
	endfunction

	always_comb begin
		t_in = thread_id[TW-1:0];
		if (priority_req >= PRI_W'(LEVELS - 1)) p_in = LW'(LEVELS - 1);
		else p_in = priority_req[LW-1:0];
	end

	assign rem_sh = {rem_q[RC_W-1:0], rnd_q[RND_W-1]};
	assign is_hit = (cmd_q == CMD_REMOVE) ? (it_q == tid_q) : (k_q == '0);

	always_comb begin
		sts.cmd = cmd_q;
		sts.tid_ok = tid_ok_q;
		sts.queued = queued_q[tid_q];
		sts.lvl_ne = lne_q[lvl_q];
		sts.scan_last = (lvl_q == '0);
		sts.mod_done = mod_done_q;
		sts.any_ready = (count_q != '0);
		sts.hit = is_hit;
		sts.more = nvalid_q[it_q];
	end

	// control state of the tables
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lne_q <= '0;
			nvalid_q <= '0;
			queued_q <= '0;
			count_q <= '0;
			found_q <= 1'b0;
			status_q <= ST_OK;
			total_q <= '0;
			tout_q <= '0;
			lout_q <= '0;
		end else begin
			if (cmd.push) begin
				queued_q[tid_q] <= 1'b1;
				lne_q[pri_q] <= 1'b1;
				count_q <= count_q + 1'b1;
				if (cmd_q == CMD_PUSH_TAIL) begin
					nvalid_q[tid_q] <= 1'b0;
					if (lne_q[pri_q]) nvalid_q[tail_q[pri_q]] <= 1'b1;
				end else nvalid_q[tid_q] <= lne_q[pri_q];
			end
			if (cmd.unlink) begin
				if (has_prev_q) nvalid_q[prev_q] <= nvalid_q[it_q];
				else if (!nvalid_q[it_q]) lne_q[lvl_q] <= 1'b0;
				nvalid_q[it_q] <= 1'b0;
				queued_q[it_q] <= 1'b0;
				count_q <= count_q - 1'b1;
			end
			if (cmd.set_res) begin
				found_q <= fnd_q;
				status_q <= st_q;
				total_q <= CNT_W'(count_q);
				tout_q <= (fnd_q && cmd_q != CMD_PEEK) ? TID_W'(it_q) : '0;
				lout_q <= fnd_q ? PRI_W'(lvl_q) : '0;
			end
		end
	end

	// payload tables and working registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q <= command;
			tid_q <= t_in;
			tid_ok_q <= (32'(thread_id) < THREADS);
			pri_q <= p_in;
			rnd_q <= random_value;
		end
		if (cmd.push) begin
			tlvl_q[tid_q] <= pri_q;
			if (cmd_q == CMD_PUSH_TAIL) begin
				if (lne_q[pri_q]) link_q[tail_q[pri_q]] <= tid_q;
				else head_q[pri_q] <= tid_q;
				tail_q[pri_q] <= tid_q;
			end else begin
				link_q[tid_q] <= head_q[pri_q];
				if (!lne_q[pri_q]) tail_q[pri_q] <= tid_q;
				head_q[pri_q] <= tid_q;
			end
		end
		if (cmd.unlink) begin
			if (has_prev_q) link_q[prev_q] <= link_q[it_q];
			else if (nvalid_q[it_q]) head_q[lvl_q] <= link_q[it_q];
			if (has_prev_q && tail_q[lvl_q] == it_q) tail_q[lvl_q] <= prev_q;
		end
		if (cmd.scan_init) lvl_q <= LW'(LEVELS - 1);
		if (cmd.scan_step) lvl_q <= lvl_q - 1'b1;
		if (cmd.walk_head && cmd_q == CMD_REMOVE) lvl_q <= tlvl_q[tid_q];
		if (cmd.mod_init) begin
			rem_q <= '0;
			mbit_q <= '0;
			mod_done_q <= 1'b0;
		end
		if (cmd.mod_step) begin
			if (rem_sh >= {1'b0, count_q}) rem_q <= rem_sh - {1'b0, count_q};
			else rem_q <= rem_sh;
			rnd_q <= {rnd_q[RND_W-2:0], 1'b0};
			mbit_q <= mbit_q + 1'b1;
			if (mbit_q == 6'(RND_W - 1)) mod_done_q <= 1'b1;
		end
		if (cmd.load) begin
			fnd_q <= 1'b0;
			st_q <= ST_OK;
			mbit_q <= '0;
		end
		if (state_set(cmd)) begin
			fnd_q <= cmd.res_found;
			st_q <= cmd.res_status;
		end
		// walk start: head of the current level
		if (cmd.walk_head) begin
			has_prev_q <= 1'b0;
			if (cmd_q == CMD_REMOVE) it_q <= head_q[tlvl_q[tid_q]];
			else it_q <= head_q[lvl_q];
		end
		if (cmd.walk_step) begin
			has_prev_q <= 1'b1;
			prev_q <= it_q;
			it_q <= link_q[it_q];
			if (k_q != '0) k_q <= k_q - 1'b1;
		end
		if (cmd.scan_init && cmd_q == CMD_POP_RAND) k_q <= rem_q[RC_W-1:0];
		if (cmd.scan_init && cmd_q != CMD_POP_RAND) k_q <= '0;
		// a scan step that leaves a nonempty level also counts its last entry
		if (cmd.scan_step && cmd_q == CMD_POP_RAND && sts.lvl_ne) k_q <= k_q - 1'b1;
	end

	assign found = found_q;
	assign thread_out = tout_q;
	assign level_out = lout_q;
	assign status = status_q;
	assign ready_total = total_q;
endmodule

@@ src/priority_ready_queue_unit.sv @@
// priority ready queue, top level: controller plus datapath
// depends on prq_pkg, prq_ctrl, prq_dpath, assert_macros.svh
//
// usage: one request channel (in_valid/in_stall with command, thread_id,
// priority_req, random_value) and one result channel (out_valid/out_stall
// with found, thread_out, level_out, status, ready_total). each request
// yields exactly one result.
// one request is worked at a time; in_stall is high while it is in flight.
// push, unknown commands and misses found at decode go from decode straight
// to the result state; pop and peek scan the levels from the top, one level
// a cycle (up to LEVELS); remove and pop random walk the level list, with a
// settle state after each link; pop random first runs a restoring modulo.
// at reset all levels and threads are empty and the count is zero; no
// clearing pass is needed.
// a stalled result is held in the output register; the next request is
// accepted but its result waits until the held one is taken.
`include "assert_macros.svh"
module priority_ready_queue_unit #(
	parameter int THREADS = prq_pkg::THREADS_DEF,
	parameter int LEVELS = prq_pkg::LEVELS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic [prq_pkg::CMD_W-1:0] command,
	input  logic [prq_pkg::TID_W-1:0] thread_id,
	input  logic [prq_pkg::PRI_W-1:0] priority_req,
	input  logic [prq_pkg::RND_W-1:0] random_value,
	output logic out_valid,
	input  logic out_stall,
	output logic found,
	output logic [prq_pkg::TID_W-1:0] thread_out,
	output logic [prq_pkg::PRI_W-1:0] level_out,
	output logic [prq_pkg::STAT_W-1:0] status,
	output logic [prq_pkg::CNT_W-1:0] ready_total
);
	import prq_pkg::*;

	prq_cmd_t cmd;
	prq_sts_t sts;

	prq_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.out_valid(out_valid), .out_stall(out_stall), .sts(sts), .cmd(cmd)
	);

	prq_dpath #(.THREADS(THREADS), .LEVELS(LEVELS)) u_dpath (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.command(command), .thread_id(thread_id), .priority_req(priority_req),
		.random_value(random_value), .found(found), .thread_out(thread_out),
		.level_out(level_out), .status(status), .ready_total(ready_total)
	);

	`ASSERT_IMPL(a_found_ok, clk, arst_n, out_valid && found, status == ST_OK)
	`ASSERT_IMPL(a_total_range, clk, arst_n, out_valid, ready_total <= CNT_W'(THREADS))
	`ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && !in_stall, in_stall)
endmodule

@@ test/prq_checker.sv @@
`timescale 1ns / 1ps
// checker for the priority ready queue: watches both channels, keeps its own
// per-level thread lists and compares every result; depends on prq_pkg
module prq_checker (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic in_stall,
	input  logic [prq_pkg::CMD_W-1:0] command,
	input  logic [prq_pkg::TID_W-1:0] thread_id,
	input  logic [prq_pkg::PRI_W-1:0] priority_req,
	input  logic [prq_pkg::RND_W-1:0] random_value,
	input  logic out_valid,
	input  logic out_stall,
	input  logic found,
	input  logic [prq_pkg::TID_W-1:0] thread_out,
	input  logic [prq_pkg::PRI_W-1:0] level_out,
	input  logic [prq_pkg::STAT_W-1:0] status,
	input  logic [prq_pkg::CNT_W-1:0] ready_total,
	output int errors,
	output int pending,
	output int results_seen
);
	import prq_pkg::*;

	typedef struct packed {
		logic found;
		logic [TID_W-1:0] thread;
		logic [PRI_W-1:0] level;
		logic [STAT_W-1:0] status;
		logic [CNT_W-1:0] total;
	} outcome_t;

	// each level is an ordered list of thread ids, head first
	logic [TID_W-1:0] level_list[LEVELS_DEF][$];
	bit queued[THREADS_DEF];
	int ready;
	outcome_t expected_q[$];

	function automatic outcome_t queue_apply(logic [CMD_W-1:0] cmd, logic [TID_W-1:0] tid,
			logic [PRI_W-1:0] pr, logic [RND_W-1:0] rnd);
		outcome_t o;
		int k;
		bit done;
		o = '0;
		o.status = ST_OK;
		case (cmd)
			CMD_PUSH_TAIL, CMD_PUSH_HEAD: begin
				if (queued[tid]) begin
					o.status = ST_DUP;
				end else begin
					queued[tid] = 1;
					ready++;
					if (cmd == CMD_PUSH_TAIL) level_list[pr].push_back(tid);
					else level_list[pr].push_front(tid);
				end
			end
			CMD_REMOVE: begin
				o.status = ST_MISS;
				if (queued[tid]) begin
					for (int l = 0; l < LEVELS_DEF; l++)
						for (int i = 0; i < level_list[l].size(); i++)
							if (level_list[l][i] == tid) begin
								level_list[l].delete(i);
								o.status = ST_OK;
								break;
							end
					queued[tid] = 0;
					ready--;
				end
			end
			CMD_POP, CMD_PEEK: begin
				o.status = ST_MISS;
				for (int l = LEVELS_DEF - 1; l >= 0; l--)
					if (level_list[l].size() > 0) begin
						o.found = 1;
						o.status = ST_OK;
						o.level = PRI_W'(l);
						if (cmd == CMD_POP) begin
							o.thread = level_list[l].pop_front();
							queued[o.thread] = 0;
							ready--;
						end
						break;
					end
			end
			CMD_POP_RAND: begin
				o.status = ST_MISS;
				if (ready > 0) begin
					k = int'(rnd % ready);
					done = 0;
					for (int l = LEVELS_DEF - 1; l >= 0 && !done; l--) begin
						if (k < level_list[l].size()) begin
							o.thread = level_list[l][k];
							level_list[l].delete(k);
							o.found = 1;
							o.status = ST_OK;
							o.level = PRI_W'(l);
							queued[o.thread] = 0;
							ready--;
							done = 1;
						end else begin
							k -= level_list[l].size();
						end
					end
				end
			end
			default: ;
		endcase
		o.total = CNT_W'(ready);
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		outcome_t e;
		if (!arst_n) begin
			errors <= 0;
			results_seen <= 0;
			pending <= 0;
			expected_q.delete();
			for (int l = 0; l < LEVELS_DEF; l++) level_list[l].delete();
			for (int t = 0; t < THREADS_DEF; t++) queued[t] = 0;
			ready = 0;
		end else begin
			if (in_valid && !in_stall)
				expected_q.push_back(queue_apply(command, thread_id, priority_req,
					random_value));
			if (out_valid && !out_stall) begin
				results_seen <= results_seen + 1;
				if (expected_q.size() == 0) begin
					$error("result with no request waiting");
					errors <= errors + 1;
				end else begin
					e = expected_q.pop_front();
					if (found !== e.found || thread_out !== e.thread
							|| level_out !== e.level || status !== e.status
							|| ready_total !== e.total) begin
						errors <= errors + 1;
						if (found !== e.found)
							$error("found: expected %0d, got %0d", e.found, found);
						if (thread_out !== e.thread)
							$error("thread_out: expected %0d, got %0d", e.thread, thread_out);
						if (level_out !== e.level)
							$error("level_out: expected %0d, got %0d", e.level, level_out);
						if (status !== e.status)
							$error("status: expected %0d, got %0d", e.status, status);
						if (ready_total !== e.total)
							$error("ready_total: expected %0d, got %0d", e.total, ready_total);
					end
				end
			end
			pending <= expected_q.size();
		end
	end
endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// top of the ready queue test: clock, reset, directed and random requests,
// receiver stalls and the verdict; depends on prq_pkg, prq_checker and the unit
module testbench;
	import prq_pkg::*;

	localparam int WATCHDOG = 20000;
	// command codes with no operation behind them
	localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
	localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

	logic clk, arst_n;
	logic in_valid, in_stall, out_valid, out_stall;
	logic [CMD_W-1:0] command;
	logic [TID_W-1:0] thread_id;
	logic [PRI_W-1:0] priority_req;
	logic [RND_W-1:0] random_value;
	logic found;
	logic [TID_W-1:0] thread_out;
	logic [PRI_W-1:0] level_out;
	logic [STAT_W-1:0] status;
	logic [CNT_W-1:0] ready_total;
	int errors, pending, results_seen;
	int send_idle_pct, stall_pct, hold_off, idle_cycles;
	int sent;
	logic hold_go, hold_used;

	priority_ready_queue_unit dut (.*);
	prq_checker checker_i (.*);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	// receiver stalls; a long hold-off fills the unit while requests keep coming
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 0;
			hold_off <= 0;
			hold_used <= 0;
		end else if (hold_go && !hold_used) begin
			hold_used <= 1;
			hold_off <= 300;
			out_stall <= 1;
		end else if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			out_stall <= 1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// watchdog on cycles with nothing accepted
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
			else idle_cycles <= idle_cycles + 1;
			if (idle_cycles > WATCHDOG) begin
				$display("watchdog expired");
				$display("status: fail");
				$finish;
			end
		end
	end

	task automatic issue(logic [CMD_W-1:0] c, logic [TID_W-1:0] t, logic [PRI_W-1:0] p,
			logic [RND_W-1:0] r);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		command <= c;
		thread_id <= t;
		priority_req <= p;
		random_value <= r;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sent++;
	endtask

	function automatic logic [CMD_W-1:0] CMD_CODE_UNUSED();
		return $urandom_range(1) ? CMD_SPARE_LO : CMD_SPARE_HI;
	endfunction

	task automatic random_request();
		int pick;
		logic [CMD_W-1:0] c;
		pick = $urandom_range(99);
		if (pick < 30) c = CMD_PUSH_TAIL;
		else if (pick < 50) c = CMD_PUSH_HEAD;
		else if (pick < 62) c = CMD_REMOVE;
		else if (pick < 74) c = CMD_POP;
		else if (pick < 82) c = CMD_PEEK;
		else if (pick < 97) c = CMD_POP_RAND;
		else c = CMD_CODE_UNUSED();
		issue(c, $urandom_range(63),
			($urandom_range(3) == 0) ? $urandom_range(31) : $urandom_range(3) * 10,
			$urandom());
	endtask

	initial begin
		arst_n = 0;
		in_valid = 0;
		command = '0;
		thread_id = '0;
		priority_req = '0;
		random_value = '0;
		send_idle_pct = 0;
		stall_pct = 0;
		hold_go = 0;
		sent = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: empty queue, extremes, duplicates, head and tail order
		issue(CMD_POP, 0, 0, 0);
		issue(CMD_PEEK, 0, 0, 0);
		issue(CMD_POP_RAND, 0, 0, 32'hffffffff);
		issue(CMD_REMOVE, 63, 0, 0);
		issue(CMD_PUSH_TAIL, 0, 0, 0);
		issue(CMD_PUSH_TAIL, 63, 31, 32'hffffffff);
		issue(CMD_PUSH_TAIL, 63, 5, 0);
		issue(CMD_PUSH_HEAD, 0, 31, 0);
		issue(CMD_PUSH_TAIL, 21, 31, 0);
		issue(CMD_PUSH_HEAD, 42, 31, 0);
		issue(CMD_PUSH_HEAD, 7, 0, 0);
		issue(CMD_PEEK, 0, 0, 0);
		issue(CMD_REMOVE, 21, 0, 0);
		issue(CMD_REMOVE, 21, 0, 0);
		issue(CMD_POP_RAND, 0, 0, 32'hffffffff);
		issue(CMD_POP_RAND, 0, 0, 32'h55555555);
		issue(CMD_SPARE_LO, 42, 31, 32'haaaaaaaa);
		issue(CMD_SPARE_HI, 21, 10, 0);
		issue(CMD_POP, 0, 0, 0);
		issue(CMD_POP, 0, 0, 0);
		issue(CMD_POP, 0, 0, 0);
		issue(CMD_PEEK, 0, 0, 0);

		for (int phase = 0; phase < 4; phase++) begin
			send_idle_pct = (phase == 1 || phase == 3) ? 77 : 0;
			stall_pct = (phase == 2) ? 77 : (phase == 3) ? 15 : 0;
			if (phase == 3) send_idle_pct = 15;
			if (phase == 0) hold_go <= 1;
			repeat (120) random_request();
		end
		in_valid <= 0;
		stall_pct = 0;

		@(posedge clk);
		while (pending > 0) @(posedge clk);
		repeat (200) @(posedge clk);
		$display("sent %0d requests, checked %0d results across four idle/stall phases",
			sent, results_seen);
		if (errors == 0 && pending == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule
